/* hdl/trifid_pkg.sv */
// Shared types, constants and symbol helpers for the trifid cipher engine.
package trifid_pkg;

  // Alphabet codes
  localparam logic [7:0] CHAR_A   = 8'h61;
  localparam logic [7:0] CHAR_Z   = 8'h7a;
  localparam logic [7:0] CHAR_DOT = 8'h2e;
  localparam logic [4:0] SYM_DOT  = 5'd26;
  localparam int unsigned NUM_LETTERS = 26;

  // One input request
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } in_req_t;

  // One result
  typedef struct packed {
    logic [7:0] result_char;
    logic       run_end;
    logic       truncated;
  } out_res_t;

  // Which digit of a stored character a read selects
  typedef enum logic [1:0] {
    FLD_LAYER  = 2'd0,
    FLD_COLUMN = 2'd1,
    FLD_ROW    = 2'd2
  } fld_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // take the input character
    logic clear;  // end of message: zero count and overflow
    logic prep;   // set up read pointers
    logic step;   // issue one digit read
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_nz;  // message holds at least one character after this load
    logic last;     // current read is the last one of the message
  } dp_stat_t;

  // Stored digits of a character: {layer, row, column}
  typedef struct packed {
    logic [1:0] layer;
    logic [1:0] row;
    logic [1:0] column;
  } digits_t;

  // True when the code belongs to the alphabet
  function automatic logic sym_ok(input logic [7:0] code);
    sym_ok = ((code >= CHAR_A) && (code <= CHAR_Z)) || (code == CHAR_DOT);
  endfunction

  // Split a code of the alphabet into its layer, row and column digits
  function automatic digits_t sym_digits(input logic [7:0] code);
    logic [4:0] idx;
    logic [4:0] rem9;
    digits_t    d;
    idx = (code == CHAR_DOT) ? SYM_DOT : 5'(code - CHAR_A);
    if (idx >= 5'd18) begin
      d.layer = 2'd2;
    end else if (idx >= 5'd9) begin
      d.layer = 2'd1;
    end else begin
      d.layer = 2'd0;
    end
    rem9 = idx - 5'(d.layer) * 5'd9;
    if (rem9 >= 5'd6) begin
      d.row = 2'd2;
    end else if (rem9 >= 5'd3) begin
      d.row = 2'd1;
    end else begin
      d.row = 2'd0;
    end
    d.column = 2'(rem9 - 5'(d.row) * 5'd3);
    sym_digits = d;
  endfunction

  // Map layer, row and column back to an ASCII code
  function automatic logic [7:0] sym_char(input logic [1:0] lay, input logic [1:0] row,
                                          input logic [1:0] col);
    logic [4:0] idx;
    idx = 5'(lay) * 5'd9 + 5'(row) * 5'd3 + 5'(col);
    sym_char = (idx < 5'(NUM_LETTERS)) ? (CHAR_A + 8'(idx)) : CHAR_DOT;
  endfunction

  // Pick one digit out of a stored word
  function automatic logic [1:0] fld_pick(input digits_t d, input fld_t f);
    logic [1:0] v;
    unique case (f)
      FLD_LAYER:  v = d.layer;
      FLD_COLUMN: v = d.column;
      FLD_ROW:    v = d.row;
      default:    v = d.row;
    endcase
    fld_pick = v;
  endfunction

  // Next field in the order layer, column, row (wraps to layer)
  function automatic fld_t fld_next(input fld_t f);
    fld_t v;
    unique case (f)
      FLD_LAYER:  v = FLD_COLUMN;
      FLD_COLUMN: v = FLD_ROW;
      FLD_ROW:    v = FLD_LAYER;
      default:    v = FLD_LAYER;
    endcase
    fld_next = v;
  endfunction

endpackage

/* hdl/trifid_ctrl.sv */
// Controller state machine: load, pointer set-up and the emit sweep.
module trifid_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                is_final,
  input  trifid_pkg::dp_stat_t stat,
  output trifid_pkg::dp_cmd_t  cmd,
  output logic                busy
);

  trifid_pkg::state_t state_r;
  trifid_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trifid_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      trifid_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (is_final) begin
            if (stat.fill_nz) begin
              state_nxt = trifid_pkg::ST_PREP;
            end else begin
              // empty message: just reset the flags
              cmd.clear = 1'b1;
            end
          end
        end
      end
      trifid_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = trifid_pkg::ST_EMIT;
      end
      trifid_pkg::ST_EMIT: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          cmd.clear = 1'b1;
          state_nxt = trifid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = trifid_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/trifid_dpath.sv */
// Datapath: character store, digit read pointers and result stage.
module trifid_dpath #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  trifid_pkg::dp_cmd_t  cmd,
  output trifid_pkg::dp_stat_t stat,
  input  trifid_pkg::in_req_t  in_data,
  input  logic                 cfg_we,
  input  logic                 cfg_dir,
  output logic                 out_valid,
  output trifid_pkg::out_res_t out_data
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  // Character store, one digit triple per entry
  trifid_pkg::digits_t mem [MAX_LEN];
  trifid_pkg::digits_t mem_q_r;

  logic          dir_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  // running n/3, n%3 and 2n/3, 2n%3 of the fill count
  logic [AW-1:0] q1_r, q1_nxt, q2_r, q2_nxt;
  logic [1:0]    r1_r, r1_nxt, r2_r, r2_nxt;

  // read pointers: entry and field; pointer 0 alone walks the enciphering sequence
  logic [AW-1:0]    ptr_c_r [3];
  trifid_pkg::fld_t ptr_f_r [3];
  logic [CW-1:0]    k_r;
  logic [1:0]       slot_r;

  // read pipeline
  logic             rd_vld_r;
  logic [1:0]       rd_slot_r;
  trifid_pkg::fld_t rd_fld_r;
  logic             rd_last_r;
  logic             rd_trunc_r;
  logic [1:0]       lay_r, col_r;
  logic             out_valid_r;
  trifid_pkg::out_res_t out_data_r;

  logic                sym_hit;
  logic                wr_en;
  trifid_pkg::digits_t wr_word;
  logic [1:0]          sel;
  logic [AW-1:0]       rd_addr;
  logic [1:0]          digit;
  logic                last;

  // Input decode
  assign sym_hit = trifid_pkg::sym_ok(in_data.char_code);
  assign wr_word = trifid_pkg::sym_digits(in_data.char_code);
  assign wr_en   = cmd.load && sym_hit && (count_r < CW'(MAX_LEN));

  // Read selection
  assign sel     = dir_r ? slot_r : 2'd0;
  assign rd_addr = ptr_c_r[sel];
  assign last    = (slot_r == 2'd2) && ((k_r + CW'(1)) == count_r);

  assign stat.fill_nz = (count_r != '0) || sym_hit;
  assign stat.last    = last;

  // Direction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (cfg_we) begin
      dir_r <= cfg_dir;
    end
  end

  // Fill count, overflow flag and thirds of the count
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    q1_nxt    = q1_r;
    r1_nxt    = r1_r;
    q2_nxt    = q2_r;
    r2_nxt    = r2_r;
    if (cmd.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      q1_nxt    = '0;
      r1_nxt    = 2'd0;
      q2_nxt    = '0;
      r2_nxt    = 2'd0;
    end else if (cmd.load && sym_hit) begin
      if (wr_en) begin
        count_nxt = count_r + CW'(1);
        if (r1_r == 2'd2) begin
          r1_nxt = 2'd0;
          q1_nxt = q1_r + AW'(1);
        end else begin
          r1_nxt = r1_r + 2'd1;
        end
        if (r2_r == 2'd0) begin
          r2_nxt = 2'd2;
        end else begin
          r2_nxt = r2_r - 2'd1;
          q2_nxt = q2_r + AW'(1);
        end
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      q1_r    <= '0;
      r1_r    <= 2'd0;
      q2_r    <= '0;
      r2_r    <= 2'd0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      q1_r    <= q1_nxt;
      r1_r    <= r1_nxt;
      q2_r    <= q2_nxt;
      r2_r    <= r2_nxt;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_word;
    end
    if (cmd.step) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Pointer set-up and advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      slot_r <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        ptr_c_r[i] <= '0;
        ptr_f_r[i] <= trifid_pkg::FLD_LAYER;
      end
    end else if (cmd.prep) begin
      k_r        <= '0;
      slot_r     <= 2'd0;
      ptr_c_r[0] <= '0;
      ptr_f_r[0] <= trifid_pkg::FLD_LAYER;
      ptr_c_r[1] <= q1_r;
      ptr_f_r[1] <= trifid_pkg::fld_t'(r1_r);
      ptr_c_r[2] <= q2_r;
      ptr_f_r[2] <= trifid_pkg::fld_t'(r2_r);
    end else if (cmd.step) begin
      if (slot_r == 2'd2) begin
        slot_r <= 2'd0;
        k_r    <= k_r + CW'(1);
      end else begin
        slot_r <= slot_r + 2'd1;
      end
      if (dir_r) begin
        // deciphering: step one digit along the per-character triples
        if (ptr_f_r[sel] == trifid_pkg::FLD_ROW) begin
          ptr_c_r[sel] <= ptr_c_r[sel] + AW'(1);
        end
        ptr_f_r[sel] <= trifid_pkg::fld_next(ptr_f_r[sel]);
      end else begin
        // enciphering: walk one whole digit plane, then the next
        if ((CW'(ptr_c_r[sel]) + CW'(1)) == count_r) begin
          ptr_c_r[sel] <= '0;
          ptr_f_r[sel] <= trifid_pkg::fld_next(ptr_f_r[sel]);
        end else begin
          ptr_c_r[sel] <= ptr_c_r[sel] + AW'(1);
        end
      end
    end
  end

  // Read tags are registered alongside the store read, so they line up with its output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_slot_r  <= slot_r;
      rd_fld_r   <= ptr_f_r[sel];
      rd_last_r  <= last;
      rd_trunc_r <= ovf_r;
    end
  end

  assign digit = trifid_pkg::fld_pick(mem_q_r, rd_fld_r);

  // Gather layer and column, finish the symbol on the row digit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rd_vld_r && (rd_slot_r == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      unique case (rd_slot_r)
        2'd0: lay_r <= digit;
        2'd1: col_r <= digit;
        2'd2: begin
          out_data_r.result_char <= trifid_pkg::sym_char(lay_r, digit, col_r);
          out_data_r.run_end     <= rd_last_r;
          out_data_r.truncated   <= rd_trunc_r;
        end
        default: lay_r <= lay_r;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/trifid_cipher_engine.sv */
// Top level of the trifid cipher engine: controller plus datapath.
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+------------------------------
//  input   | start, busy, in_data                | taken when start & !busy
//  result  | out_valid, out_data                 | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_direction | written when valid & ready
//
// A character is loaded while the engine is idle. The final request is followed by
// a set-up state and then three store reads per result (one store port, three
// digits per symbol), during which busy stays high; each result passes the store
// read register and the result register after its last read. Reset (rst_n low,
// synchronous) empties the message and sets direction to enciphering; results
// cannot be held off by the receiver.
module trifid_cipher_engine #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  trifid_pkg::in_req_t  in_data,
  output logic                 out_valid,
  output trifid_pkg::out_res_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_direction
);

  trifid_pkg::dp_cmd_t  cmd;
  trifid_pkg::dp_stat_t stat;

  // Direction register always takes a write
  assign cfg_ready = 1'b1;

  trifid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .is_final (in_data.is_final),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  trifid_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_dir   (cfg_direction),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/tb_trifid_cipher_engine.sv */
// Self-checking testbench for the trifid cipher engine: directed table, then random messages.
module tb_trifid_cipher_engine;

  localparam int unsigned MAX_LEN      = 32;
  localparam int unsigned RAND_ITEMS   = 430;
  localparam int unsigned PHASE_ITEMS  = 60;
  localparam int unsigned DRAIN_CYCLES = 4 * MAX_LEN + 8;
  localparam int unsigned N_ROWS       = 21;

  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  // How a directed row is checked
  typedef enum logic {
    CHK_MODEL,
    CHK_FIXED
  } chk_t;

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
    chk_t       chk;
    logic [7:0] sym;
  } stim_row_t;

  // Directed requests; fixed rows are one-character messages, which map to themselves
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    {8'h61, 1'b1, CHK_FIXED, 8'h61},  // 'a' alone
    {8'h2e, 1'b1, CHK_FIXED, 8'h2e},  // '.' alone
    {8'h7a, 1'b1, CHK_FIXED, 8'h7a},  // 'z' alone
    {8'h00, 1'b1, CHK_MODEL, 8'h00},  // empty message
    {8'hff, 1'b0, CHK_MODEL, 8'h00},  // outside the alphabet, dropped
    {8'h6a, 1'b0, CHK_MODEL, 8'h00},
    {8'h60, 1'b0, CHK_MODEL, 8'h00},  // just below 'a'
    {8'h6b, 1'b0, CHK_MODEL, 8'h00},
    {8'h7b, 1'b0, CHK_MODEL, 8'h00},  // just above 'z'
    {8'h2d, 1'b0, CHK_MODEL, 8'h00},  // either side of '.'
    {8'h2f, 1'b0, CHK_MODEL, 8'h00},
    {8'h6c, 1'b1, CHK_MODEL, 8'h00},
    {8'h61, 1'b0, CHK_MODEL, 8'h00},
    {8'h62, 1'b0, CHK_MODEL, 8'h00},
    {8'h63, 1'b0, CHK_MODEL, 8'h00},
    {8'h79, 1'b0, CHK_MODEL, 8'h00},
    {8'h7a, 1'b0, CHK_MODEL, 8'h00},
    {8'h2e, 1'b1, CHK_MODEL, 8'h00},
    {8'h80, 1'b0, CHK_MODEL, 8'h00},
    {8'h61, 1'b0, CHK_MODEL, 8'h00},
    {8'h7f, 1'b1, CHK_MODEL, 8'h00}   // final request carrying a dropped character
  };

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 start         = 1'b0;
  trifid_pkg::in_req_t  in_data       = '0;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_direction = 1'b0;
  logic                 busy;
  logic                 out_valid;
  trifid_pkg::out_res_t out_data;
  logic                 cfg_ready;

  // Predictor state: stored digits, fill level, overflow flag, direction
  logic [1:0]  held_layer [MAX_LEN];
  logic [1:0]  held_row   [MAX_LEN];
  logic [1:0]  held_col   [MAX_LEN];
  int unsigned held_n   = 0;
  logic        held_cut = 1'b0;
  logic        cipher_dir = DIR_ENC;

  trifid_pkg::out_res_t cipher_q [$];
  trifid_pkg::out_res_t want;
  int unsigned fail_cnt = 0;
  int unsigned item_cnt = 0;

  trifid_cipher_engine #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_direction(cfg_direction)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store one character and, on the final request, work out the cipher text
  function automatic void trifid_absorb(input logic [7:0] code, input logic fin,
                                        input logic keep);
    int unsigned idx;
    int unsigned k;
    int unsigned n;
    logic [1:0]  seq [3*MAX_LEN];
    logic [1:0]  l;
    logic [1:0]  c;
    logic [1:0]  r;
    int unsigned s;
    trifid_pkg::out_res_t res;
    if (code >= trifid_pkg::CHAR_A && code <= trifid_pkg::CHAR_Z) begin
      idx = code - trifid_pkg::CHAR_A;
    end else if (code == trifid_pkg::CHAR_DOT) begin
      idx = 26;
    end else begin
      idx = 27;
    end
    if (idx < 27) begin
      if (held_n < MAX_LEN) begin
        held_layer[held_n] = 2'(idx / 9);
        held_row[held_n]   = 2'((idx % 9) / 3);
        held_col[held_n]   = 2'(idx % 3);
        held_n++;
      end else begin
        held_cut = 1'b1;
      end
    end
    if (!fin) return;
    n = held_n;
    // enciphering lays out layers, columns, rows; deciphering lays out triples
    for (k = 0; k < n; k++) begin
      if (cipher_dir == DIR_ENC) begin
        seq[k]       = held_layer[k];
        seq[n + k]   = held_col[k];
        seq[2*n + k] = held_row[k];
      end else begin
        seq[3*k]     = held_layer[k];
        seq[3*k + 1] = held_col[k];
        seq[3*k + 2] = held_row[k];
      end
    end
    for (k = 0; k < n; k++) begin
      if (cipher_dir == DIR_ENC) begin
        l = seq[3*k];
        c = seq[3*k + 1];
        r = seq[3*k + 2];
      end else begin
        l = seq[k];
        c = seq[n + k];
        r = seq[2*n + k];
      end
      s = 9 * l + 3 * r + c;
      res.result_char = (s < 26) ? trifid_pkg::CHAR_A + 8'(s) : trifid_pkg::CHAR_DOT;
      res.run_end     = (k + 1 == n);
      res.truncated   = held_cut;
      if (keep) cipher_q.push_back(res);
    end
    held_n   = 0;
    held_cut = 1'b0;
  endfunction

  function automatic logic [7:0] alpha_code();
    int unsigned idx;
    idx = $urandom_range(0, 26);
    return (idx < 26) ? trifid_pkg::CHAR_A + 8'(idx) : trifid_pkg::CHAR_DOT;
  endfunction

  // Random idle bursts between requests, none in a calm stretch
  function automatic int unsigned pick_gap(input logic calm);
    if (calm || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  // Present one request and hold it until the engine takes it
  task automatic send_char(input logic [7:0] code, input logic fin, input int unsigned gap,
                           input chk_t chk, input logic [7:0] sym);
    trifid_pkg::out_res_t res;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= {code, fin};
    do @(posedge clk); while (busy);
    if (chk == CHK_FIXED) begin
      trifid_absorb(code, fin, 1'b0);
      res.result_char = sym;
      res.run_end     = 1'b1;
      res.truncated   = 1'b0;
      cipher_q.push_back(res);
    end else begin
      trifid_absorb(code, fin, 1'b1);
    end
  endtask

  // Let every pending result arrive and the engine fall quiet
  task automatic settle();
    start <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input logic dir);
    cfg_valid     <= 1'b1;
    cfg_direction <= dir;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    cipher_dir = dir;
  endtask

  // One random message: mostly clean text, sometimes empty, full or overlong, with noise
  task automatic send_message();
    int unsigned len;
    int unsigned i;
    int unsigned pick;
    logic        calm;
    logic        noise_last;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      len = 0;
    end else if (pick <= 2) begin
      len = MAX_LEN + $urandom_range(0, 6);
    end else if (pick == 3) begin
      len = $urandom_range(9, MAX_LEN);
    end else begin
      len = $urandom_range(1, 8);
    end
    calm       = (item_cnt >= RAND_ITEMS * 85 / 100) || ($urandom_range(0, 2) == 0);
    noise_last = (len == 0) || ($urandom_range(0, 7) == 0);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_char(8'($urandom_range(0, 255)), 1'b0, pick_gap(calm), CHK_MODEL, 8'h00);
      end
      send_char(alpha_code(), (i + 1 == len) && !noise_last, pick_gap(calm),
                CHK_MODEL, 8'h00);
      item_cnt++;
    end
    if (noise_last) begin
      send_char(8'($urandom_range(0, 255)), 1'b1, pick_gap(calm), CHK_MODEL, 8'h00);
      item_cnt++;
    end
  endtask

  // Result checker: the receiver cannot stall, so every strobe is taken
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cipher_q.size() == 0) begin
        $error("result_char: nothing pending, actual %h", out_data.result_char);
        fail_cnt++;
      end else begin
        want = cipher_q.pop_front();
        if (out_data.result_char !== want.result_char) begin
          $error("result_char: expected %h, actual %h", want.result_char,
                 out_data.result_char);
          fail_cnt++;
        end
        if (out_data.run_end !== want.run_end) begin
          $error("run_end: expected %b, actual %b", want.run_end, out_data.run_end);
          fail_cnt++;
        end
        if (out_data.truncated !== want.truncated) begin
          $error("truncated: expected %b, actual %b", want.truncated, out_data.truncated);
          fail_cnt++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned i;
    int unsigned phase;
    int unsigned next_phase_at;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, enciphering straight out of reset
    for (i = 0; i < N_ROWS; i++) begin
      send_char(DIRECTED[i].code, DIRECTED[i].fin, pick_gap(i >= 12), DIRECTED[i].chk,
                DIRECTED[i].sym);
    end

    // random phases, direction rewritten while the engine is quiet
    phase         = 0;
    next_phase_at = 0;
    while (item_cnt < RAND_ITEMS) begin
      if (item_cnt >= next_phase_at) begin
        settle();
        if (phase == 0) begin
          write_direction(DIR_DEC);
        end else if (phase == 1) begin
          write_direction(DIR_ENC);
        end else begin
          write_direction($urandom_range(0, 1) ? DIR_DEC : DIR_ENC);
        end
        phase++;
        next_phase_at = item_cnt + PHASE_ITEMS;
      end
      send_message();
    end

    start <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
